// ===== hw/rtl/rgv_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rgv_pkg: shared types and widths for the rhombus guidance vector block
// Word formats, derived datapath widths and register indexes.
// ----------------------------------------------------------------------------
package rgv_pkg;

  localparam int COORD_WIDTH   = 24;
  localparam int OUT_FRAC_BITS = 14;

  localparam int CENTER_W = 24;
  localparam int RADIUS_W = 23;
  localparam int DIR_W    = 2;
  localparam int GAIN_W   = 16;
  localparam int CFG_W    = 24;
  localparam int IDX_W    = 3;
  localparam int OUT_W    = 16;

  // datapath widths
  localparam int DW   = ((COORD_WIDTH > CENTER_W) ? COORD_WIDTH : CENTER_W) + 1;
  localparam int SUMW = DW + 1;
  localparam int EW   = SUMW + 1;
  localparam int KW   = EW + GAIN_W;
  localparam int VW   = KW + 1;
  localparam int MW   = VW;
  localparam int NW   = 30;
  localparam int SHW  = $clog2(MW - NW + 2);
  localparam int SQW  = 2 * NW + 1;
  localparam int RW   = NW + 1;
  localparam int QW   = OUT_FRAC_BITS + 1;
  localparam int NUMW = NW + OUT_FRAC_BITS + 1;

  typedef enum logic [IDX_W-1:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_RADIUS    = 3'd2,
    REG_DIRECTION = 3'd3,
    REG_GAIN      = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] point_x;
    logic signed [COORD_WIDTH-1:0] point_y;
  } point_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] vector_x;
    logic signed [OUT_W-1:0] vector_y;
  } vector_t;

  // sideband that rides along the square root
  typedef struct packed {
    logic [NW-1:0] a;
    logic [NW-1:0] b;
    logic          neg_x;
    logic          neg_y;
    logic          zero;
  } side_t;

  // active configuration
  typedef struct packed {
    logic signed [CENTER_W-1:0] center_x;
    logic signed [CENTER_W-1:0] center_y;
    logic [RADIUS_W-1:0]        radius;
    logic signed [DIR_W-1:0]    direction;
    logic [GAIN_W-1:0]          gain;
  } cfg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rgv_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rgv_front: raw vector and range reduction
// Ten stages from the query point to the shifted magnitudes and a^2+b^2.
// ----------------------------------------------------------------------------
module rgv_front import rgv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire point_t      point,
  input  wire cfg_t        cfg,
  output logic             valid,
  output logic [SQW-1:0]   sum,
  output side_t            side
);

  logic [9:0] v;

  logic signed [DW-1:0]  dx, dy;
  logic [DW-1:0]         mx, my;
  logic                  g1n2, g2n2, g1n3, g2n3, g1n4, g2n4;
  logic signed [EW-1:0]  e;
  logic signed [KW-1:0]  k;
  logic signed [VW-1:0]  vx, vy;
  logic [MW-1:0]         ax, ay, ax7, ay7, m;
  logic                  nx6, ny6, nx7, ny7, nx8, ny8, nx9, ny9;
  logic                  z7, z8, z9;
  logic [NW-1:0]         a8, b8, a9, b9;
  logic [SQW-1:0]        aa, bb;

  logic signed [DW-1:0]  px_ext, py_ext, cx_ext, cy_ext;
  logic signed [VW-1:0]  u, tx, ty, kx, ky, k_ext;
  logic [SHW-1:0]        sh;

  assign px_ext = DW'(point.point_x);
  assign py_ext = DW'(point.point_y);
  assign cx_ext = DW'(cfg.center_x);
  assign cy_ext = DW'(cfg.center_y);

  // tangent magnitude is one in Q.16 (zero when direction is zero), sign from direction
  always_comb begin
    if (cfg.direction[DIR_W-1]) begin
      u = -VW'(65536);
    end else if (cfg.direction != '0) begin
      u = VW'(65536);
    end else begin
      u = '0;
    end
    k_ext = VW'(k);
    tx = g2n4 ? -u : u;
    ty = g1n4 ? u : -u;
    kx = g1n4 ? -k_ext : k_ext;
    ky = g2n4 ? -k_ext : k_ext;
  end

  always_comb begin
    sh = '0;
    for (int i = NW; i < MW; i++) begin
      if (m[i]) sh = SHW'(i - NW + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[8:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx   <= px_ext - cx_ext;
      dy   <= py_ext - cy_ext;
      mx   <= dx[DW-1] ? DW'(-dx) : DW'(dx);
      my   <= dy[DW-1] ? DW'(-dy) : DW'(dy);
      g1n2 <= dx[DW-1];
      g2n2 <= dy[DW-1];
      e    <= $signed(EW'(mx) + EW'(my)) - $signed(EW'(cfg.radius));
      g1n3 <= g1n2;
      g2n3 <= g2n2;
      k    <= KW'(e) * KW'($signed({1'b0, cfg.gain}));
      g1n4 <= g1n3;
      g2n4 <= g2n3;
      vx   <= tx - kx;
      vy   <= ty - ky;
      ax   <= vx[VW-1] ? MW'(-vx) : MW'(vx);
      ay   <= vy[VW-1] ? MW'(-vy) : MW'(vy);
      nx6  <= vx[VW-1];
      ny6  <= vy[VW-1];
      m    <= (ax > ay) ? ax : ay;
      z7   <= (ax == '0) && (ay == '0);
      ax7  <= ax;
      ay7  <= ay;
      nx7  <= nx6;
      ny7  <= ny6;
      a8   <= NW'(ax7 >> sh);
      b8   <= NW'(ay7 >> sh);
      nx8  <= nx7;
      ny8  <= ny7;
      z8   <= z7;
      aa   <= SQW'(a8) * SQW'(a8);
      bb   <= SQW'(b8) * SQW'(b8);
      a9   <= a8;
      b9   <= b8;
      nx9  <= nx8;
      ny9  <= ny8;
      z9   <= z8;
      sum  <= aa + bb;
      side <= '{a: a9, b: b9, neg_x: nx9, neg_y: ny9, zero: z9};
    end
  end

  assign valid = v[9];

endmodule
`default_nettype wire

// ===== hw/rtl/rgv_sqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rgv_sqrt: pipelined integer square root
// One result bit per stage, floor(sqrt(sum)).
// ----------------------------------------------------------------------------
module rgv_sqrt import rgv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [SQW-1:0] sum,
  input  wire side_t       in_side,
  output logic             valid,
  output logic [RW-1:0]    root,
  output side_t            side
);

  logic [SQW-1:0] x_q [RW];
  logic [SQW-1:0] r_q [RW];
  side_t          s_q [RW];
  logic [RW-1:0]  v_q;

  for (genvar i = 0; i < RW; i++) begin : g_stage
    localparam logic [SQW:0] BIT = (SQW+1)'(1) << (2 * (RW - 1 - i));
    logic [SQW-1:0] x_in, r_in;
    logic [SQW:0]   trial;
    logic           v_in;
    side_t          s_in;

    if (i == 0) begin : g_first
      assign x_in = sum;
      assign r_in = '0;
      assign v_in = in_valid;
      assign s_in = in_side;
    end else begin : g_next
      assign x_in = x_q[i-1];
      assign r_in = r_q[i-1];
      assign v_in = v_q[i-1];
      assign s_in = s_q[i-1];
    end

    assign trial = {1'b0, r_in} + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[i] <= 1'b0;
      end else if (en) begin
        v_q[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_q[i] <= s_in;
        if ({1'b0, x_in} >= trial) begin
          x_q[i] <= SQW'({1'b0, x_in} - trial);
          r_q[i] <= SQW'((r_in >> 1) + BIT);
        end else begin
          x_q[i] <= x_in;
          r_q[i] <= r_in >> 1;
        end
      end
    end
  end

  assign valid = v_q[RW-1];
  assign root  = r_q[RW-1][RW-1:0];
  assign side  = s_q[RW-1];

endmodule
`default_nettype wire

// ===== hw/rtl/rgv_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rgv_div: two-lane pipelined divider and output register
// Rounded quotient a*2^F/norm per component, then sign and saturation, or zero when flagged.
// ----------------------------------------------------------------------------
module rgv_div import rgv_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [RW-1:0] root,
  input  wire side_t       in_side,
  output logic             valid,
  output vector_t          vector
);

  localparam int SATW = ((QW > OUT_W) ? QW : OUT_W) + 1;

  // prep stage
  logic [NUMW-1:0] nx0, ny0;
  logic [RW-1:0]   nrm0;
  logic [2:0]      fl0;
  logic            v0;

  logic [NUMW-1:0] rx_q [QW];
  logic [NUMW-1:0] ry_q [QW];
  logic [QW-1:0]   qx_q [QW];
  logic [QW-1:0]   qy_q [QW];
  logic [RW-1:0]   n_q  [QW];
  logic [2:0]      f_q  [QW];
  logic [QW-1:0]   v_q;

  function automatic logic [OUT_W-1:0] finish(input logic [QW-1:0] q, input logic neg);
    logic [SATW-1:0] qe;
    logic [SATW-1:0] lim;
    qe = SATW'(q);
    lim = neg ? SATW'(32768) : SATW'(32767);
    if (qe > lim) qe = lim;
    if (neg) begin
      finish = OUT_W'(-qe);
    end else begin
      finish = OUT_W'(qe);
    end
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      nx0  <= {in_side.a, {OUT_FRAC_BITS{1'b0}}} + NUMW'(root >> 1);
      ny0  <= {in_side.b, {OUT_FRAC_BITS{1'b0}}} + NUMW'(root >> 1);
      nrm0 <= root;
      fl0  <= {in_side.neg_x, in_side.neg_y, in_side.zero};
    end
  end

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [NUMW-1:0] rx_in, ry_in;
    logic [QW-1:0]   qx_in, qy_in;
    logic [RW-1:0]   n_in;
    logic [2:0]      f_in;
    logic            v_in;
    logic [NUMW:0]   d;
    logic            gx, gy;

    if (j == 0) begin : g_first
      assign rx_in = nx0;
      assign ry_in = ny0;
      assign qx_in = '0;
      assign qy_in = '0;
      assign n_in  = nrm0;
      assign f_in  = fl0;
      assign v_in  = v0;
    end else begin : g_next
      assign rx_in = rx_q[j-1];
      assign ry_in = ry_q[j-1];
      assign qx_in = qx_q[j-1];
      assign qy_in = qy_q[j-1];
      assign n_in  = n_q[j-1];
      assign f_in  = f_q[j-1];
      assign v_in  = v_q[j-1];
    end

    assign d  = (NUMW+1)'(n_in) << (QW - 1 - j);
    assign gx = {1'b0, rx_in} >= d;
    assign gy = {1'b0, ry_in} >= d;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[j] <= 1'b0;
      end else if (en) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rx_q[j] <= gx ? NUMW'({1'b0, rx_in} - d) : rx_in;
        ry_q[j] <= gy ? NUMW'({1'b0, ry_in} - d) : ry_in;
        qx_q[j] <= {qx_in[QW-2:0], gx};
        qy_q[j] <= {qy_in[QW-2:0], gy};
        n_q[j]  <= n_in;
        f_q[j]  <= f_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= v_q[QW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (f_q[QW-1][0]) begin
        vector <= '0;
      end else begin
        vector.vector_x <= finish(qx_q[QW-1], f_q[QW-1][2]);
        vector.vector_y <= finish(qy_q[QW-1], f_q[QW-1][1]);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/rhombus_guidance_vector.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rhombus_guidance_vector: guiding vector field toward a rhombus path
// Top level: configuration registers, pipeline flow control, stage wiring.
// ----------------------------------------------------------------------------
// Each point word gives one unit guidance vector word (Q1.14) that steers
// toward the rhombus set by center_x/center_y/radius, with travel sense from
// the sign of direction and convergence set by gain. The block takes one word
// per clock unless the output word is held, and is fully pipelined: 10 front
// stages (offset, error, gain multiply, raw vector, range shift, squares),
// 31 square root stages, one divider setup stage, 15 divider stages and the
// output register. The whole pipeline holds while a finished result waits
// for vector_ready, so point_ready follows vector_ready when the output
// register is full. A zero raw vector gives a zero output. Write
// configuration only with the pipeline empty; cfg_ready is always high and
// an index beyond gain is dropped.
module rhombus_guidance_vector import rgv_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              point_valid,
  output logic                   point_ready,
  input  wire point_t            point,
  output logic                   vector_valid,
  input  wire logic              vector_ready,
  output vector_t                vector,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]  cfg_data
);

  cfg_t            cfg;
  logic            en;
  logic            f_valid, s_valid;
  logic [SQW-1:0]  f_sum;
  side_t           f_side, s_side;
  logic [RW-1:0]   s_root;

  // advance everything unless the output word is held
  assign en          = !vector_valid || vector_ready;
  assign point_ready = en;
  assign cfg_ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.center_x  <= '0;
      cfg.center_y  <= '0;
      cfg.radius    <= '0;
      cfg.direction <= DIR_W'(1);
      cfg.gain      <= GAIN_W'(256);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CENTER_X:  cfg.center_x  <= cfg_data[CENTER_W-1:0];
        REG_CENTER_Y:  cfg.center_y  <= cfg_data[CENTER_W-1:0];
        REG_RADIUS:    cfg.radius    <= cfg_data[RADIUS_W-1:0];
        REG_DIRECTION: cfg.direction <= cfg_data[DIR_W-1:0];
        REG_GAIN:      cfg.gain      <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  rgv_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (point_valid),
    .point    (point),
    .cfg      (cfg),
    .valid    (f_valid),
    .sum      (f_sum),
    .side     (f_side)
  );

  rgv_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (f_valid),
    .sum      (f_sum),
    .in_side  (f_side),
    .valid    (s_valid),
    .root     (s_root),
    .side     (s_side)
  );

  rgv_div u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (s_valid),
    .root     (s_root),
    .in_side  (s_side),
    .valid    (vector_valid),
    .vector   (vector)
  );

endmodule
`default_nettype wire
